// File: rtl/tfpc_pkg.sv
// shared widths, register indexes and types for the target follow controller
`timescale 1ns / 1ps

package tfpc_pkg;

    localparam int unsigned PIX_W   = 12;
    localparam int unsigned CLASS_W = 8;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned LIMIT_W = 15;
    localparam int unsigned AREA_W  = 25;
    localparam int unsigned THR_W   = 24;
    localparam int unsigned CMD_W   = 16;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_AREA_THRESHOLD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRACKED_CLASS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_GAIN        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_LIMIT       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_LIMIT      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_DIST        = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_CONTROL_ON = 3'd7;

    // fraction bits of the two gains
    localparam int unsigned TURN_FRAC  = 8;
    localparam int unsigned SPEED_FRAC = 12;

    typedef struct packed {
        logic [THR_W-1:0]   area_threshold;
        logic [CLASS_W-1:0] tracked_class;
        logic [GAIN_W-1:0]  turn_gain;
        logic [GAIN_W-1:0]  speed_gain;
        logic [LIMIT_W-1:0] turn_limit;
        logic [LIMIT_W-1:0] speed_limit;
        logic [DIST_W-1:0]  hold_dist;
        logic               speed_control_on;
    } cfg_t;

endpackage

// File: rtl/target_follow_p_controller.sv
// target follow proportional controller: best box pick and clamped turn / speed command
//
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  box_valid, x_left, y_top, x_right, y_bottom,
//                                            class_id, target_distance, frame_end
//  out       source     out_valid/out_stall  target_found, center_x, turn_rate, forward_speed
//  cfg       sink       cfg_write            cfg_index, cfg_data
//
//  one beat accepted every cycle while in_stall is low; only frame end beats give a command
//  five register stages: input, area product, best box pick, gain products, output
//  the best box register is the only loop, one compare per cycle unless the stage behind it is stalled
//  reset clears all valids and the best box state and sets the configuration registers to their defaults
//  a stalled output fills the stages behind it one by one before in_stall rises
`timescale 1ns / 1ps

module target_follow_p_controller #(
    parameter int unsigned FRAME_WIDTH  = 640,
    parameter int unsigned VALID_MIN_MM = 50,
    parameter int unsigned VALID_MAX_MM = 5000
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 box_valid,
    input  logic [tfpc_pkg::PIX_W-1:0]           x_left,
    input  logic [tfpc_pkg::PIX_W-1:0]           y_top,
    input  logic [tfpc_pkg::PIX_W-1:0]           x_right,
    input  logic [tfpc_pkg::PIX_W-1:0]           y_bottom,
    input  logic [tfpc_pkg::CLASS_W-1:0]         class_id,
    input  logic [tfpc_pkg::DIST_W-1:0]          target_distance,
    input  logic                                 frame_end,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 target_found,
    output logic [tfpc_pkg::PIX_W-1:0]           center_x,
    output logic signed [tfpc_pkg::CMD_W-1:0]    turn_rate,
    output logic signed [tfpc_pkg::CMD_W-1:0]    forward_speed,

    input  logic                                 cfg_write,
    input  logic [tfpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tfpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // frame centre column and the inclusive distance window
    localparam logic [tfpc_pkg::PIX_W-1:0]  HALF_WIDTH = tfpc_pkg::PIX_W'(FRAME_WIDTH / 2);
    localparam logic [tfpc_pkg::DIST_W-1:0] DIST_MIN   = tfpc_pkg::DIST_W'(VALID_MIN_MM);
    localparam logic [tfpc_pkg::DIST_W-1:0] DIST_MAX   = tfpc_pkg::DIST_W'(VALID_MAX_MM);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    tfpc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.area_threshold   <= 24'd20;
            cfg_reg.tracked_class    <= 8'd0;
            cfg_reg.turn_gain        <= 16'd2560;
            cfg_reg.speed_gain       <= 16'd2048;
            cfg_reg.turn_limit       <= 15'd1500;
            cfg_reg.speed_limit      <= 15'd100;
            cfg_reg.hold_dist        <= 16'd300;
            cfg_reg.speed_control_on <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tfpc_pkg::CFG_AREA_THRESHOLD:   cfg_reg.area_threshold   <= cfg_data;
                tfpc_pkg::CFG_TRACKED_CLASS:    cfg_reg.tracked_class    <= cfg_data[7:0];
                tfpc_pkg::CFG_TURN_GAIN:        cfg_reg.turn_gain        <= cfg_data[15:0];
                tfpc_pkg::CFG_SPEED_GAIN:       cfg_reg.speed_gain       <= cfg_data[15:0];
                tfpc_pkg::CFG_TURN_LIMIT:       cfg_reg.turn_limit       <= cfg_data[14:0];
                tfpc_pkg::CFG_SPEED_LIMIT:      cfg_reg.speed_limit      <= cfg_data[14:0];
                tfpc_pkg::CFG_HOLD_DIST:        cfg_reg.hold_dist        <= cfg_data[15:0];
                tfpc_pkg::CFG_SPEED_CONTROL_ON: cfg_reg.speed_control_on <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valids and the ready chain, each stage moves when the next frees up
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic fe2_reg;

    assign rdy5 = !out_valid_reg || !out_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_stall  = !rdy1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            // only frame end beats carry on past the pick stage
            if (rdy3)
                v3_reg <= v2_reg && fe2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                out_valid_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic                            bv1_reg, fe1_reg;
    logic [tfpc_pkg::PIX_W-1:0]      xl1_reg, yt1_reg, xr1_reg, yb1_reg;
    logic [tfpc_pkg::CLASS_W-1:0]    cls1_reg;
    logic [tfpc_pkg::DIST_W-1:0]     dist1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            bv1_reg   <= box_valid;
            xl1_reg   <= x_left;
            yt1_reg   <= y_top;
            xr1_reg   <= x_right;
            yb1_reg   <= y_bottom;
            cls1_reg  <= class_id;
            dist1_reg <= target_distance;
            fe1_reg   <= frame_end;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: signed box area, centre and class match
    // ------------------------------------------------------------------
    logic signed [tfpc_pkg::PIX_W:0]       dx, dy;
    logic signed [2*tfpc_pkg::PIX_W+1:0]   area_full;
    logic [tfpc_pkg::PIX_W:0]              x_sum;

    // reversed edges give a negative width or height
    assign dx        = $signed({1'b0, xr1_reg}) - $signed({1'b0, xl1_reg});
    assign dy        = $signed({1'b0, yb1_reg}) - $signed({1'b0, yt1_reg});
    assign area_full = dx * dy;
    assign x_sum     = {1'b0, xl1_reg} + {1'b0, xr1_reg};

    logic signed [tfpc_pkg::AREA_W-1:0] area2_reg;
    logic [tfpc_pkg::PIX_W-1:0]         center2_reg;
    logic                               match2_reg;
    logic [tfpc_pkg::DIST_W-1:0]        dist2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            area2_reg   <= area_full[tfpc_pkg::AREA_W-1:0];
            center2_reg <= x_sum[tfpc_pkg::PIX_W:1];
            match2_reg  <= bv1_reg && (cls1_reg == cfg_reg.tracked_class);
            dist2_reg   <= dist1_reg;
            fe2_reg     <= fe1_reg;
        end
    end

    // ------------------------------------------------------------------
    // best box pick: strictly larger than threshold, then than the best so far
    // ------------------------------------------------------------------
    logic signed [tfpc_pkg::AREA_W-1:0] best_area_reg;
    logic [tfpc_pkg::PIX_W-1:0]         best_center_reg;
    logic                               found_reg;

    logic signed [tfpc_pkg::AREA_W:0]   floor_v;
    logic                               take;
    logic                               pick_step;
    logic                               found_upd;
    logic [tfpc_pkg::PIX_W-1:0]         center_upd;

    assign floor_v    = found_reg ? {best_area_reg[tfpc_pkg::AREA_W-1], best_area_reg}
                                  : $signed({2'b00, cfg_reg.area_threshold});
    assign take       = match2_reg &&
                        ($signed({area2_reg[tfpc_pkg::AREA_W-1], area2_reg}) > floor_v);
    assign pick_step  = v2_reg && rdy3;
    assign found_upd  = found_reg || take;
    assign center_upd = take ? center2_reg : best_center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_area_reg   <= '0;
            best_center_reg <= '0;
            found_reg       <= 1'b0;
        end
        else if (pick_step)
        begin
            if (fe2_reg)
            begin
                // frame closed, start the next one clean
                best_area_reg   <= '0;
                best_center_reg <= '0;
                found_reg       <= 1'b0;
            end
            else if (take)
            begin
                best_area_reg   <= area2_reg;
                best_center_reg <= center2_reg;
                found_reg       <= 1'b1;
            end
        end
    end

    logic                        found3_reg;
    logic [tfpc_pkg::PIX_W-1:0]  cx3_reg;
    logic [tfpc_pkg::DIST_W-1:0] dist3_reg;

    always_ff @(posedge clk)
    begin
        if (pick_step && fe2_reg)
        begin
            found3_reg <= found_upd;
            cx3_reg    <= found_upd ? center_upd : '0;
            dist3_reg  <= dist2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: error terms times gains
    // ------------------------------------------------------------------
    logic signed [tfpc_pkg::PIX_W+1:0]                turn_err;
    logic signed [tfpc_pkg::DIST_W+1:0]               speed_err;
    logic signed [tfpc_pkg::GAIN_W+tfpc_pkg::PIX_W+2:0]  turn_prod;
    logic signed [tfpc_pkg::GAIN_W+tfpc_pkg::DIST_W+2:0] speed_prod;
    logic                                             in_window;

    assign turn_err   = $signed({2'b00, HALF_WIDTH}) - $signed({2'b00, cx3_reg});
    assign speed_err  = $signed({2'b00, dist3_reg}) - $signed({2'b00, cfg_reg.hold_dist});
    assign turn_prod  = $signed({1'b0, cfg_reg.turn_gain}) * turn_err;
    assign speed_prod = $signed({1'b0, cfg_reg.speed_gain}) * speed_err;
    assign in_window  = (dist3_reg >= DIST_MIN) && (dist3_reg <= DIST_MAX);

    logic                                                found4_reg;
    logic [tfpc_pkg::PIX_W-1:0]                          cx4_reg;
    logic                                                win4_reg;
    logic signed [tfpc_pkg::GAIN_W+tfpc_pkg::PIX_W+2:0]  turn4_reg;
    logic signed [tfpc_pkg::GAIN_W+tfpc_pkg::DIST_W+2:0] speed4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            found4_reg <= found3_reg;
            cx4_reg    <= cx3_reg;
            win4_reg   <= in_window;
            turn4_reg  <= turn_prod;
            speed4_reg <= speed_prod;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: round half away from zero, clamp to the limits
    // ------------------------------------------------------------------
    localparam int unsigned TP_W = tfpc_pkg::GAIN_W + tfpc_pkg::PIX_W + 3;
    localparam int unsigned SP_W = tfpc_pkg::GAIN_W + tfpc_pkg::DIST_W + 3;

    logic [TP_W-1:0] turn_mag, turn_rnd;
    logic [SP_W-1:0] speed_mag, speed_rnd;
    logic [tfpc_pkg::LIMIT_W-1:0] turn_clip, speed_clip;
    logic signed [tfpc_pkg::CMD_W-1:0] turn_cmd, speed_cmd;

    always_comb
    begin
        turn_mag  = turn4_reg[TP_W-1] ? TP_W'(-turn4_reg) : TP_W'(turn4_reg);
        turn_rnd  = (turn_mag + (TP_W'(1) << (tfpc_pkg::TURN_FRAC - 1))) >> tfpc_pkg::TURN_FRAC;
        turn_clip = (turn_rnd > TP_W'(cfg_reg.turn_limit)) ? cfg_reg.turn_limit
                                                         : turn_rnd[tfpc_pkg::LIMIT_W-1:0];
        turn_cmd  = turn4_reg[TP_W-1] ? -$signed({1'b0, turn_clip}) : $signed({1'b0, turn_clip});

        speed_mag  = speed4_reg[SP_W-1] ? SP_W'(-speed4_reg) : SP_W'(speed4_reg);
        speed_rnd  = (speed_mag + (SP_W'(1) << (tfpc_pkg::SPEED_FRAC - 1)))
                     >> tfpc_pkg::SPEED_FRAC;
        speed_clip = (speed_rnd > SP_W'(cfg_reg.speed_limit)) ? cfg_reg.speed_limit
                                                            : speed_rnd[tfpc_pkg::LIMIT_W-1:0];
        speed_cmd  = speed4_reg[SP_W-1] ? -$signed({1'b0, speed_clip})
                                        : $signed({1'b0, speed_clip});

        // outside the window or with speed control off the speed is zero; with no target both commands are zero
        if (!found4_reg)
            turn_cmd = '0;
        if (!found4_reg || !win4_reg || !cfg_reg.speed_control_on)
            speed_cmd = '0;
    end

    logic                              found_out_reg;
    logic [tfpc_pkg::PIX_W-1:0]        cx_out_reg;
    logic signed [tfpc_pkg::CMD_W-1:0] turn_out_reg, speed_out_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            found_out_reg <= found4_reg;
            cx_out_reg    <= cx4_reg;
            turn_out_reg  <= turn_cmd;
            speed_out_reg <= speed_cmd;
        end
    end

    assign target_found  = found_out_reg;
    assign center_x      = cx_out_reg;
    assign turn_rate     = turn_out_reg;
    assign forward_speed = speed_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // no target means an all zero command
    a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_out_reg |->
            cx_out_reg == '0 && turn_out_reg == '0 && speed_out_reg == '0)
        else $error("command not zero without a target");

    // a box centred in the frame needs no turn
    a_centred_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_out_reg && cx_out_reg == HALF_WIDTH |-> turn_out_reg == '0)
        else $error("turn issued for a centred box");

    // a consumed frame end leaves the pick state clear
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pick_step && fe2_reg |=> !found_reg && best_area_reg == '0 && best_center_reg == '0)
        else $error("best box state not cleared at frame end");

    // stall only with the input and area stages occupied
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg)
        else $error("input stalled with free stages");

endmodule
